FILE: sv/round_robin_thread_scheduler_unit_defines.svh
// Assertion macros used by the scheduler top-level module.
// The enclosing module must provide clk and rst_n.
`ifndef ROUND_ROBIN_THREAD_SCHEDULER_UNIT_DEFINES_SVH
`define ROUND_ROBIN_THREAD_SCHEDULER_UNIT_DEFINES_SVH

`define RRTS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scheduler assertion failed");

`define RRTS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scheduler assertion failed");

`endif

FILE: sv/rrts_pkg.sv
package rrts_pkg;

  localparam int THREAD_SLOTS = 16;
  localparam int IDX_W        = $clog2(THREAD_SLOTS);
  localparam int CNT_W        = $clog2(THREAD_SLOTS + 1);

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  localparam idx_t       LAST_IDX  = idx_t'(THREAD_SLOTS - 1);
  localparam cnt_t       SCAN_LAST = cnt_t'(THREAD_SLOTS);
  localparam logic [8:0] TID_LIMIT = 9'(THREAD_SLOTS);

  typedef enum logic [2:0] {
    REQ_CREATE  = 3'd0,
    REQ_YIELD   = 3'd1,
    REQ_BLOCK   = 3'd2,
    REQ_WAKE    = 3'd3,
    REQ_EXIT    = 3'd4,
    REQ_JOIN    = 3'd5,
    REQ_DESTROY = 3'd6
  } req_t;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_NO_FREE   = 2'd1,
    STS_BAD_ID    = 2'd2,
    STS_JOIN_WAIT = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    TS_FREE     = 3'd0,
    TS_READY    = 3'd1,
    TS_RUNNING  = 3'd2,
    TS_BLOCKED  = 3'd3,
    TS_FINISHED = 3'd4
  } thread_state_t;

  typedef struct packed {
    idx_t          addr;
    logic          we_state;
    thread_state_t state;
    logic          we_fin;
    logic          fin;
    logic          we_join;
    logic          join_valid;
    idx_t          join_index;
    logic          we_value;
    logic [31:0]   value;
  } tbl_wr_t;

  typedef struct packed {
    thread_state_t state;
    logic          fin;
    logic          join_valid;
    idx_t          join_index;
    logic [31:0]   value;
  } tbl_rd_t;

  typedef struct packed {
    status_t            status;
    logic               switched;
    logic [7:0]         running_thread;
    logic [7:0]         created_thread;
    logic signed [31:0] exit_value_out;
  } rsp_t;

  function automatic idx_t idx_inc(idx_t v);
    return (v == LAST_IDX) ? '0 : idx_t'(v + 1'b1);
  endfunction

endpackage

FILE: sv/rrts_if.sv
interface rrts_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         req_type;
  logic [7:0]         target_id;
  logic signed [31:0] exit_value_in;

  modport source (output valid, req_type, target_id, exit_value_in, input ready);
  modport sink   (input valid, req_type, target_id, exit_value_in, output ready);
endinterface

interface rrts_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic               switched;
  logic [7:0]         running_thread;
  logic [7:0]         created_thread;
  logic signed [31:0] exit_value_out;

  modport source (output valid, status, switched, running_thread, created_thread,
                  exit_value_out, input ready);
  modport sink   (input valid, status, switched, running_thread, created_thread,
                  exit_value_out, output ready);
endinterface

FILE: sv/rrts_table.sv
module rrts_table import rrts_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  tbl_wr_t wr,
  output tbl_rd_t rd
);

  thread_state_t state_r [THREAD_SLOTS];
  logic          fin_r   [THREAD_SLOTS];
  logic          jv_r    [THREAD_SLOTS];
  idx_t          ji_r    [THREAD_SLOTS];
  logic [31:0]   value_r [THREAD_SLOTS];

  // Waiter index and saved value are only read once their flags are set.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < THREAD_SLOTS; i++) begin
        state_r[i] <= (i == 0) ? TS_RUNNING : TS_FREE;
        fin_r[i]   <= 1'b0;
        jv_r[i]    <= 1'b0;
      end
    end else begin
      if (wr.we_state) state_r[wr.addr] <= wr.state;
      if (wr.we_fin)   fin_r[wr.addr]   <= wr.fin;
      if (wr.we_join)  jv_r[wr.addr]    <= wr.join_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.we_join)  ji_r[wr.addr]    <= wr.join_index;
    if (wr.we_value) value_r[wr.addr] <= wr.value;
  end

  assign rd.state      = state_r[wr.addr];
  assign rd.fin        = fin_r[wr.addr];
  assign rd.join_valid = jv_r[wr.addr];
  assign rd.join_index = ji_r[wr.addr];
  assign rd.value      = value_r[wr.addr];

endmodule

FILE: sv/rrts_ctrl.sv
module rrts_ctrl import rrts_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  rrts_req_if.sink in_req,
  input  logic    out_free,
  output logic    rsp_load,
  output rsp_t    rsp_data
);

  typedef enum logic [12:0] {
    S_IDLE    = 13'b0000000000001,
    S_CREATE  = 13'b0000000000010,
    S_BLOCK   = 13'b0000000000100,
    S_WAKE    = 13'b0000000001000,
    S_EXIT    = 13'b0000000010000,
    S_EXWAKE  = 13'b0000000100000,
    S_JOIN    = 13'b0000001000000,
    S_JBLK    = 13'b0000010000000,
    S_DESTROY = 13'b0000100000000,
    S_SCHED   = 13'b0001000000000,
    S_SWAP1   = 13'b0010000000000,
    S_SWAP2   = 13'b0100000000000,
    S_DONE    = 13'b1000000000000
  } fsm_t;

  fsm_t               state_r, state_nxt;
  idx_t               cur_r, cur_nxt;
  idx_t               before_r, before_nxt;
  idx_t               ptr_r, ptr_nxt;
  cnt_t               cnt_r, cnt_nxt;
  idx_t               found_r, found_nxt;
  idx_t               waiter_r, waiter_nxt;
  logic [7:0]         tid_r, tid_nxt;
  logic signed [31:0] xval_r, xval_nxt;
  status_t            status_r, status_nxt;
  logic [7:0]         created_r, created_nxt;
  logic signed [31:0] xout_r, xout_nxt;
  tbl_wr_t            wr;
  tbl_rd_t            rd;
  logic               tid_ok;
  idx_t               tid_idx;

  rrts_table u_table (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (wr),
    .rd    (rd)
  );

  assign in_req.ready = (state_r == S_IDLE);
  assign tid_ok       = ({1'b0, in_req.target_id} < TID_LIMIT);
  assign tid_idx      = tid_r[IDX_W-1:0];

  assign rsp_data.status         = status_r;
  assign rsp_data.switched       = (cur_r != before_r);
  assign rsp_data.running_thread = 8'(cur_r);
  assign rsp_data.created_thread = created_r;
  assign rsp_data.exit_value_out = xout_r;

  always_comb begin
    state_nxt   = state_r;
    cur_nxt     = cur_r;
    before_nxt  = before_r;
    ptr_nxt     = ptr_r;
    cnt_nxt     = cnt_r;
    found_nxt   = found_r;
    waiter_nxt  = waiter_r;
    tid_nxt     = tid_r;
    xval_nxt    = xval_r;
    status_nxt  = status_r;
    created_nxt = created_r;
    xout_nxt    = xout_r;
    wr          = '0;
    rsp_load    = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_req.valid) begin
          tid_nxt     = in_req.target_id;
          xval_nxt    = in_req.exit_value_in;
          before_nxt  = cur_r;
          status_nxt  = STS_OK;
          created_nxt = '0;
          xout_nxt    = '0;
          ptr_nxt     = idx_inc(cur_r);
          cnt_nxt     = cnt_t'(1);
          case (req_t'(in_req.req_type))
            REQ_CREATE: begin
              status_nxt = STS_NO_FREE;
              ptr_nxt    = idx_t'(1);
              state_nxt  = S_CREATE;
            end
            REQ_YIELD: state_nxt = S_SCHED;
            REQ_BLOCK: state_nxt = S_BLOCK;
            REQ_WAKE: begin
              if (tid_ok) begin
                state_nxt = S_WAKE;
              end else begin
                status_nxt = STS_BAD_ID;
                state_nxt  = S_DONE;
              end
            end
            REQ_EXIT: state_nxt = S_EXIT;
            REQ_JOIN: begin
              if (tid_ok) begin
                state_nxt = S_JOIN;
              end else begin
                status_nxt = STS_BAD_ID;
                xout_nxt   = '1;
                state_nxt  = S_DONE;
              end
            end
            REQ_DESTROY: begin
              if (tid_ok && (in_req.target_id != 8'd0)) begin
                state_nxt = S_DESTROY;
              end else begin
                status_nxt = STS_BAD_ID;
                state_nxt  = S_DONE;
              end
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_CREATE: begin
        wr.addr = ptr_r;
        if (rd.state == TS_FREE) begin
          wr.we_state = 1'b1;
          wr.state    = TS_READY;
          wr.we_fin   = 1'b1;
          wr.we_join  = 1'b1;
          created_nxt = 8'(ptr_r);
          status_nxt  = STS_OK;
          state_nxt   = S_DONE;
        end else if (ptr_r == LAST_IDX) begin
          state_nxt = S_DONE;
        end else begin
          ptr_nxt = idx_inc(ptr_r);
        end
      end
      S_BLOCK: begin
        wr.addr     = cur_r;
        wr.we_state = 1'b1;
        wr.state    = TS_BLOCKED;
        state_nxt   = S_SCHED;
      end
      S_WAKE: begin
        wr.addr = tid_idx;
        if (rd.state == TS_BLOCKED) begin
          wr.we_state = 1'b1;
          wr.state    = TS_READY;
        end
        state_nxt = S_DONE;
      end
      S_EXIT: begin
        wr.addr     = cur_r;
        wr.we_state = 1'b1;
        wr.state    = TS_FINISHED;
        wr.we_fin   = 1'b1;
        wr.fin      = 1'b1;
        wr.we_value = 1'b1;
        wr.value    = xval_r;
        waiter_nxt  = rd.join_index;
        state_nxt   = rd.join_valid ? S_EXWAKE : S_SCHED;
      end
      S_EXWAKE: begin
        wr.addr = waiter_r;
        if (rd.state == TS_BLOCKED) begin
          wr.we_state = 1'b1;
          wr.state    = TS_READY;
        end
        state_nxt = S_SCHED;
      end
      S_JOIN: begin
        wr.addr = tid_idx;
        if (rd.fin) begin
          xout_nxt  = rd.value;
          state_nxt = S_DONE;
        end else begin
          wr.we_join    = 1'b1;
          wr.join_valid = 1'b1;
          wr.join_index = cur_r;
          state_nxt     = S_JBLK;
        end
      end
      S_JBLK: begin
        wr.addr     = cur_r;
        wr.we_state = 1'b1;
        wr.state    = TS_BLOCKED;
        status_nxt  = STS_JOIN_WAIT;
        state_nxt   = S_SCHED;
      end
      S_DESTROY: begin
        wr.addr     = tid_idx;
        wr.we_state = 1'b1;
        wr.state    = TS_FREE;
        state_nxt   = S_DONE;
      end
      S_SCHED: begin
        wr.addr = ptr_r;
        if (rd.state == TS_READY) begin
          found_nxt = ptr_r;
          state_nxt = S_SWAP1;
        end else if (cnt_r == SCAN_LAST) begin
          state_nxt = S_DONE;
        end else begin
          ptr_nxt = idx_inc(ptr_r);
          cnt_nxt = cnt_t'(cnt_r + 1'b1);
        end
      end
      S_SWAP1: begin
        wr.addr = cur_r;
        if (rd.state == TS_RUNNING) begin
          wr.we_state = 1'b1;
          wr.state    = TS_READY;
        end
        state_nxt = S_SWAP2;
      end
      S_SWAP2: begin
        wr.addr     = found_r;
        wr.we_state = 1'b1;
        wr.state    = TS_RUNNING;
        cur_nxt     = found_r;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          rsp_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cur_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cur_r   <= cur_nxt;
    end
  end

  always_ff @(posedge clk) begin
    before_r  <= before_nxt;
    ptr_r     <= ptr_nxt;
    cnt_r     <= cnt_nxt;
    found_r   <= found_nxt;
    waiter_r  <= waiter_nxt;
    tid_r     <= tid_nxt;
    xval_r    <= xval_nxt;
    status_r  <= status_nxt;
    created_r <= created_nxt;
    xout_r    <= xout_nxt;
  end

endmodule

FILE: sv/round_robin_thread_scheduler_unit.sv
// Round-robin cooperative thread scheduler with a 16-entry thread table.
// in_req carries one request beat (create, yield, block, wake, exit, join,
// destroy) with a target thread id and an exit status. out_rsp returns one
// beat per request: status, switch flag, running thread, created slot and
// the joined thread's exit status.
// A request is taken only while the sequencer is idle; the table is visited
// one slot per cycle through a single access port. Create scans slots 1 to
// 15 for a free one, wake and destroy touch only the target slot, and yield,
// block, exit and a waiting join scan the table for a ready thread before
// the response register is loaded.
// The next request is accepted in the cycle after the response is loaded.
// The response register lets the next request be accepted while a finished
// response still waits; if the receiver stalls, the following request holds
// in its last step until the register frees up.
// After reset thread 0 is running and all other slots are free.
`include "round_robin_thread_scheduler_unit_defines.svh"

module round_robin_thread_scheduler_unit import rrts_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  rrts_req_if.sink  in_req,
  rrts_rsp_if.source out_rsp
);

  logic rsp_load;
  logic out_free;
  rsp_t rsp_data;
  logic out_valid_r, out_valid_nxt;
  rsp_t out_data_r;

  rrts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (in_req),
    .out_free (out_free),
    .rsp_load (rsp_load),
    .rsp_data (rsp_data)
  );

  assign out_free = !out_valid_r || out_rsp.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (rsp_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) out_data_r <= rsp_data;
  end

  assign out_rsp.valid          = out_valid_r;
  assign out_rsp.status         = out_data_r.status;
  assign out_rsp.switched       = out_data_r.switched;
  assign out_rsp.running_thread = out_data_r.running_thread;
  assign out_rsp.created_thread = out_data_r.created_thread;
  assign out_rsp.exit_value_out = out_data_r.exit_value_out;

  `RRTS_ASSERT_NXT(a_busy_after_accept, in_req.valid && in_req.ready, !in_req.ready)
  `RRTS_ASSERT_IMP(a_no_overwrite, rsp_load, !out_valid_r || out_rsp.ready)
  `RRTS_ASSERT_IMP(a_running_in_range, out_valid_r,
                   {1'b0, out_rsp.running_thread} < TID_LIMIT)
  `RRTS_ASSERT_IMP(a_created_ok, out_valid_r && (out_rsp.created_thread != 8'd0),
                   out_rsp.status == STS_OK)

endmodule
